>>> rtl/json_string_unescaper_macros.svh
// Assertion macros for the JSON string unescaper.
// Each takes a label, an antecedent and a consequent; clk and rst_n come from
// the module that uses them.
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define JSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`else

`define JSU_ASSERT_NOW(lbl, ante, cons)
`define JSU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // Parser modes, one-hot
    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_STR     = 7'b0000010,
        MODE_ESC     = 7'b0000100,
        MODE_HEX     = 7'b0001000,
        MODE_HI_WAIT = 7'b0010000,
        MODE_HI_BSL  = 7'b0100000,
        MODE_LO_HEX  = 7'b1000000
    } mode_t;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_UNTERM  = 2'd0;
    localparam logic [1:0] ERR_NOQUOTE = 2'd1;
    localparam logic [1:0] ERR_ESC     = 2'd2;
    localparam logic [1:0] ERR_HEX     = 2'd3;

    // Most results one input byte can cause
    localparam int unsigned MAX_RES = 4;

    // Parser state. acc holds up to three hex digits (the fourth comes from
    // the input byte); pend holds the low ten bits of a high surrogate.
    typedef struct packed {
        mode_t       mode;
        logic [1:0]  hex_cnt;
        logic [11:0] acc;
        logic [9:0]  pend;
    } state_t;

    localparam state_t STATE_RESET = '{mode: MODE_IDLE, hex_cnt: 2'd0,
                                       acc: 12'd0, pend: 10'd0};

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] err;
    } item_t;

    // All results of one transaction
    typedef struct packed {
        logic [2:0]               cnt;
        item_t [MAX_RES-1:0]      items;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/jsu_step.sv
`default_nettype none

// Combinational decode of one text byte against the current parser state.
module jsu_step (
    input  wire jsu_pkg::state_t st,
    input  wire logic [7:0]      text_byte,
    input  wire logic            end_of_text,
    output jsu_pkg::state_t      st_next,
    output jsu_pkg::res_t        res
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;

    function automatic jsu_pkg::item_t mk_byte(input logic [7:0] data);
        jsu_pkg::item_t it;
        it      = '0;
        it.kind = jsu_pkg::KIND_BYTE;
        it.data = data;
        return it;
    endfunction

    function automatic jsu_pkg::item_t mk_done();
        jsu_pkg::item_t it;
        it      = '0;
        it.kind = jsu_pkg::KIND_DONE;
        return it;
    endfunction

    logic        hex_ok;
    logic [3:0]  hex_d;
    logic        esc_ok;
    logic [7:0]  esc_c;
    logic [15:0] unit;
    logic [1:0]  unit_len;
    logic [7:0]  unit_b0, unit_b1, unit_b2;
    logic [15:0] hi_cp;
    logic [20:0] sup_cp;
    logic        err_hit;
    logic [1:0]  err_code;
    jsu_pkg::state_t st_work;
    jsu_pkg::res_t   res_work;

    // Hex digit decode
    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (text_byte >= 8'h30 && text_byte <= 8'h39)
            hex_d = text_byte[3:0];
        else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
                 (text_byte >= 8'h41 && text_byte <= 8'h46))
            hex_d = text_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    // Single-character escapes
    always_comb
    begin
        esc_ok = 1'b1;
        esc_c  = text_byte;
        case (text_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: esc_c = text_byte;
            CH_LO_B: esc_c = CH_BS;
            CH_LO_F: esc_c = CH_FF;
            CH_LO_N: esc_c = CH_LF;
            CH_LO_R: esc_c = CH_CR;
            CH_LO_T: esc_c = CH_TAB;
            default: esc_ok = 1'b0;
        endcase
    end

    // UTF-8 encode of a completed BMP unit
    assign unit = {st.acc, hex_d};
    always_comb
    begin
        unit_b0 = unit[7:0];
        unit_b1 = 8'h00;
        unit_b2 = 8'h00;
        if (unit < 16'h0080)
        begin
            unit_len = 2'd1;
        end
        else if (unit < 16'h0800)
        begin
            unit_len = 2'd2;
            unit_b0  = {3'b110, unit[10:6]};
            unit_b1  = {2'b10, unit[5:0]};
        end
        else
        begin
            unit_len = 2'd3;
            unit_b0  = {4'b1110, unit[15:12]};
            unit_b1  = {2'b10, unit[11:6]};
            unit_b2  = {2'b10, unit[5:0]};
        end
    end

    // Held high surrogate and joined supplementary code point
    assign hi_cp  = {6'b110110, st.pend};
    assign sup_cp = 21'h010000 + {1'b0, st.pend, unit[9:0]};

    // Mode transitions and result list
    always_comb
    begin
        st_work  = st;
        res_work = '0;
        err_hit  = 1'b0;
        err_code = jsu_pkg::ERR_UNTERM;

        if (end_of_text)
        begin
            err_hit  = 1'b1;
            err_code = (st.mode == jsu_pkg::MODE_IDLE) ? jsu_pkg::ERR_NOQUOTE
                                                       : jsu_pkg::ERR_UNTERM;
        end
        else
        begin
            case (st.mode)
                jsu_pkg::MODE_IDLE:
                begin
                    if (text_byte == CH_QUOTE)
                        st_work.mode = jsu_pkg::MODE_STR;
                    else if (!(text_byte == CH_SPACE || text_byte == CH_TAB ||
                               text_byte == CH_CR || text_byte == CH_LF))
                    begin
                        err_hit  = 1'b1;
                        err_code = jsu_pkg::ERR_NOQUOTE;
                    end
                end
                jsu_pkg::MODE_STR:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        st_work.mode      = jsu_pkg::MODE_IDLE;
                        res_work.cnt      = 3'd1;
                        res_work.items[0] = mk_done();
                    end
                    else if (text_byte == CH_BSL)
                        st_work.mode = jsu_pkg::MODE_ESC;
                    else
                    begin
                        res_work.cnt      = 3'd1;
                        res_work.items[0] = mk_byte(text_byte);
                    end
                end
                jsu_pkg::MODE_ESC:
                begin
                    if (text_byte == CH_LO_U)
                    begin
                        st_work.mode    = jsu_pkg::MODE_HEX;
                        st_work.hex_cnt = 2'd0;
                        st_work.acc     = 12'd0;
                    end
                    else if (esc_ok)
                    begin
                        st_work.mode      = jsu_pkg::MODE_STR;
                        res_work.cnt      = 3'd1;
                        res_work.items[0] = mk_byte(esc_c);
                    end
                    else
                    begin
                        err_hit  = 1'b1;
                        err_code = jsu_pkg::ERR_ESC;
                    end
                end
                jsu_pkg::MODE_HEX:
                begin
                    if (!hex_ok)
                    begin
                        err_hit  = 1'b1;
                        err_code = jsu_pkg::ERR_HEX;
                    end
                    else if (st.hex_cnt != 2'd3)
                    begin
                        st_work.acc     = unit[11:0];
                        st_work.hex_cnt = st.hex_cnt + 2'd1;
                    end
                    else
                    begin
                        st_work.hex_cnt = 2'd0;
                        st_work.acc     = 12'd0;
                        if (unit[15:10] == 6'b110110)
                        begin
                            // high surrogate: hold it for a possible low unit
                            st_work.pend = unit[9:0];
                            st_work.mode = jsu_pkg::MODE_HI_WAIT;
                        end
                        else
                        begin
                            st_work.mode      = jsu_pkg::MODE_STR;
                            res_work.cnt      = {1'b0, unit_len};
                            res_work.items[0] = mk_byte(unit_b0);
                            res_work.items[1] = mk_byte(unit_b1);
                            res_work.items[2] = mk_byte(unit_b2);
                        end
                    end
                end
                jsu_pkg::MODE_HI_WAIT:
                begin
                    if (text_byte == CH_BSL)
                        st_work.mode = jsu_pkg::MODE_HI_BSL;
                    else
                    begin
                        // lone high surrogate, then the byte as in the body
                        st_work.pend      = 10'd0;
                        res_work.cnt      = 3'd4;
                        res_work.items[0] = mk_byte({4'b1110, hi_cp[15:12]});
                        res_work.items[1] = mk_byte({2'b10, hi_cp[11:6]});
                        res_work.items[2] = mk_byte({2'b10, hi_cp[5:0]});
                        if (text_byte == CH_QUOTE)
                        begin
                            st_work.mode      = jsu_pkg::MODE_IDLE;
                            res_work.items[3] = mk_done();
                        end
                        else
                        begin
                            st_work.mode      = jsu_pkg::MODE_STR;
                            res_work.items[3] = mk_byte(text_byte);
                        end
                    end
                end
                jsu_pkg::MODE_HI_BSL:
                begin
                    if (text_byte == CH_LO_U)
                    begin
                        st_work.mode    = jsu_pkg::MODE_LO_HEX;
                        st_work.hex_cnt = 2'd0;
                        st_work.acc     = 12'd0;
                    end
                    else if (esc_ok)
                    begin
                        st_work.mode      = jsu_pkg::MODE_STR;
                        st_work.pend      = 10'd0;
                        res_work.cnt      = 3'd4;
                        res_work.items[0] = mk_byte({4'b1110, hi_cp[15:12]});
                        res_work.items[1] = mk_byte({2'b10, hi_cp[11:6]});
                        res_work.items[2] = mk_byte({2'b10, hi_cp[5:0]});
                        res_work.items[3] = mk_byte(esc_c);
                    end
                    else
                    begin
                        err_hit  = 1'b1;
                        err_code = jsu_pkg::ERR_ESC;
                    end
                end
                jsu_pkg::MODE_LO_HEX:
                begin
                    if (!hex_ok)
                    begin
                        err_hit  = 1'b1;
                        err_code = jsu_pkg::ERR_HEX;
                    end
                    else if ((st.hex_cnt == 2'd0 && hex_d != 4'hD) ||
                             (st.hex_cnt == 2'd1 && hex_d < 4'hC))
                    begin
                        // not a low surrogate: flush the high one, go on as plain
                        st_work.mode      = jsu_pkg::MODE_HEX;
                        st_work.acc       = unit[11:0];
                        st_work.hex_cnt   = st.hex_cnt + 2'd1;
                        st_work.pend      = 10'd0;
                        res_work.cnt      = 3'd3;
                        res_work.items[0] = mk_byte({4'b1110, hi_cp[15:12]});
                        res_work.items[1] = mk_byte({2'b10, hi_cp[11:6]});
                        res_work.items[2] = mk_byte({2'b10, hi_cp[5:0]});
                    end
                    else if (st.hex_cnt != 2'd3)
                    begin
                        st_work.acc     = unit[11:0];
                        st_work.hex_cnt = st.hex_cnt + 2'd1;
                    end
                    else
                    begin
                        // surrogate pair complete
                        st_work.mode      = jsu_pkg::MODE_STR;
                        st_work.hex_cnt   = 2'd0;
                        st_work.acc       = 12'd0;
                        st_work.pend      = 10'd0;
                        res_work.cnt      = 3'd4;
                        res_work.items[0] = mk_byte({5'b11110, sup_cp[20:18]});
                        res_work.items[1] = mk_byte({2'b10, sup_cp[17:12]});
                        res_work.items[2] = mk_byte({2'b10, sup_cp[11:6]});
                        res_work.items[3] = mk_byte({2'b10, sup_cp[5:0]});
                    end
                end
                default:
                begin
                    err_hit  = 1'b1;
                    err_code = jsu_pkg::ERR_UNTERM;
                end
            endcase
        end

        // Any error drops everything else and restarts the parser
        if (err_hit)
        begin
            st_work             = jsu_pkg::STATE_RESET;
            res_work            = '0;
            res_work.cnt        = 3'd1;
            res_work.items[0].kind = jsu_pkg::KIND_ERR;
            res_work.items[0].err  = err_code;
        end
    end

    assign st_next = st_work;
    assign res     = res_work;

endmodule

`default_nettype wire

>>> rtl/json_string_unescaper.sv
// JSON string unescaper: one text byte per transaction in, UTF-8 bytes,
// done and error items out. A result is shown the cycle after its byte is
// accepted. A byte gives up to 4 results, held in the 4-entry output buffer;
// the next byte is accepted when the buffer is empty or as its last item leaves.
// Reset (rst_n low, asynchronous) returns the parser to idle and empties
// the output buffer.
`default_nettype none

`include "json_string_unescaper_macros.svh"

module json_string_unescaper (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      item_kind,
    output logic [7:0]      decoded_byte,
    output logic [1:0]      error_code,
    output logic            last
);

    jsu_pkg::state_t st_reg, st_next;
    jsu_pkg::res_t   res;

    jsu_pkg::item_t  item_reg [jsu_pkg::MAX_RES];
    logic [2:0]      cnt_reg, cnt_next;
    logic [1:0]      idx_reg, idx_next;

    logic in_fire, out_fire, out_last;

    jsu_step u_step (
        .st          (st_reg),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .st_next     (st_next),
        .res         (res)
    );

    // Handshakes: a new transaction may enter as the last buffered item leaves
    assign out_last  = (({1'b0, idx_reg} + 3'd1) == cnt_reg);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = !out_valid || (out_ready && out_last);
    assign in_fire   = in_valid && in_ready;

    // Output buffer occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (out_fire)
        begin
            if (out_last)
            begin
                cnt_next = 3'd0;
                idx_next = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
        if (in_fire && res.cnt != 3'd0)
        begin
            cnt_next = res.cnt;
            idx_next = 2'd0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= jsu_pkg::STATE_RESET;
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            if (in_fire)
                st_reg <= st_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire && res.cnt != 3'd0)
        begin
            for (int i = 0; i < jsu_pkg::MAX_RES; i++)
                item_reg[i] <= res.items[i];
        end
    end

    assign item_kind    = item_reg[idx_reg].kind;
    assign decoded_byte = item_reg[idx_reg].data;
    assign error_code   = item_reg[idx_reg].err;
    assign last         = out_last;

    // Checks
    `JSU_ASSERT_NOW(a_err_is_last, out_valid && item_kind == jsu_pkg::KIND_ERR, last)
    `JSU_ASSERT_NOW(a_done_is_last, out_valid && item_kind == jsu_pkg::KIND_DONE, last)
    `JSU_ASSERT_NOW(a_idx_in_range, out_valid, ({1'b0, idx_reg} < cnt_reg) && cnt_reg <= 3'd4)
    `JSU_ASSERT_NEXT(a_end_to_idle, in_fire && end_of_text, st_reg.mode == jsu_pkg::MODE_IDLE)

endmodule

`default_nettype wire
